@@ design/assert_macros.svh @@
// Assertion helpers shared by the deque RTL.
// Every macro samples on the rising edge of clk and is disabled in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression must hold at every sampled edge.
`define ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

@@ design/fad_pkg.sv @@
package fad_pkg;

  typedef enum logic [1:0] {
    ACT_PUSH_FRONT = 2'd0,
    ACT_PUSH_BACK  = 2'd1,
    ACT_POP_FRONT  = 2'd2,
    ACT_POP_BACK   = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_FRONT_FULL = 3'd1,
    ST_REAR_FULL  = 3'd2,
    ST_NEVER_USED = 3'd3,
    ST_EMPTY      = 3'd4
  } status_t;

  // Outcome of one action, decided in the cycle the beat is accepted.
  typedef struct packed {
    logic    pop_ok;
    status_t status;
  } fad_res_t;

endpackage

@@ design/fad_ram.sv @@
module fad_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ design/fad_ctrl.sv @@
`include "assert_macros.svh"

module fad_ctrl import fad_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     accept,
  input  action_t                  action,
  output logic                     we,
  output logic                     re,
  output logic [$clog2(DEPTH)-1:0] addr,
  output fad_res_t                 res
);

  localparam int IDX_W  = $clog2(DEPTH + 1);
  localparam int ADDR_W = $clog2(DEPTH);

  logic [IDX_W-1:0] head, head_next;
  logic [IDX_W-1:0] tail, tail_next;
  logic             started, started_next;
  logic [IDX_W-1:0] idx;
  logic             wr, rd;

  always_comb begin
    head_next    = head;
    tail_next    = tail;
    started_next = started;
    idx          = '0;
    wr           = 1'b0;
    rd           = 1'b0;
    res.pop_ok   = 1'b0;
    res.status   = ST_OK;
    case (action)
      ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
        if (!started) begin
          // The very first push lands at entry 0 whichever end it names.
          wr           = 1'b1;
          head_next    = '0;
          tail_next    = IDX_W'(1);
          started_next = 1'b1;
        end else if (action == ACT_PUSH_FRONT) begin
          if (head != '0) begin
            wr        = 1'b1;
            idx       = head - 1'b1;
            head_next = head - 1'b1;
          end else begin
            res.status = ST_FRONT_FULL;
          end
        end else begin
          if (tail < IDX_W'(DEPTH)) begin
            wr        = 1'b1;
            idx       = tail;
            tail_next = tail + 1'b1;
          end else begin
            res.status = ST_REAR_FULL;
          end
        end
      end
      default: begin
        if (!started) begin
          res.status = ST_NEVER_USED;
        end else if (head == tail) begin
          res.status = ST_EMPTY;
        end else if (action == ACT_POP_FRONT) begin
          rd         = 1'b1;
          res.pop_ok = 1'b1;
          idx        = head;
          head_next  = head + 1'b1;
        end else begin
          rd         = 1'b1;
          res.pop_ok = 1'b1;
          idx        = tail - 1'b1;
          tail_next  = tail - 1'b1;
        end
      end
    endcase
  end

  assign we   = accept & wr;
  assign re   = accept & rd;
  assign addr = idx[ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      head    <= '0;
      tail    <= '0;
      started <= 1'b0;
    end else if (accept) begin
      head    <= head_next;
      tail    <= tail_next;
      started <= started_next;
    end
  end

  `ASSERT_ALWAYS(a_head_le_tail, head <= tail, "deque head passed tail")
  `ASSERT_ALWAYS(a_tail_in_range, tail <= IDX_W'(DEPTH), "deque tail beyond depth")
  `ASSERT_SAME(a_unused_idle, !started, head == '0 && tail == '0, "indices moved before use")
  `ASSERT_NEXT(a_first_push, accept && !started && !action[1], started && head == '0 && tail == IDX_W'(1), "first push misplaced")

endmodule

@@ design/fixed_array_deque.sv @@
// Double-ended queue over a fixed, non-circular array of DEPTH words.
// Input stream (s_axis): tuser carries the action (push front, push back,
// pop front, pop back), tdata the word to push. Output stream (m_axis):
// one beat per input beat, in order; tdata carries the popped word (zero
// unless a pop succeeded), tuser the status code.
// The first push after reset lands at entry 0; a front push needs free room
// below the head, a back push room above the tail, and room freed by a pop
// is reused only by a push at the same end until reset.
// A result reaches m_axis after its input beat is accepted by way of the
// indices and the synchronous RAM access, then the output register.
// Throughput is one beat per cycle while m_axis is not stalled, set by the
// single RAM port pair, which sees one read or one write per accepted beat.
// Reset (rst, synchronous) empties the deque and marks it unused; the RAM
// contents are not cleared since only written entries are ever read.
// When m_axis stalls, the output register and the one beat behind it hold,
// and s_axis_tready drops until the output moves again.
module fixed_array_deque import fad_pkg::*; #(
  parameter int DEPTH      = 4,
  parameter int DATA_WIDTH = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [((DATA_WIDTH+7)/8)*8-1:0]     s_axis_tdata,  // value
  input  logic [1:0]                          s_axis_tuser,  // action
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [((DATA_WIDTH+7)/8)*8-1:0]     m_axis_tdata,  // popped
  output logic [2:0]                          m_axis_tuser   // status
);

  localparam int TDATA_W = ((DATA_WIDTH + 7) / 8) * 8;
  localparam int ADDR_W  = $clog2(DEPTH);

  logic                  accept;
  logic                  ram_we, ram_re;
  logic [ADDR_W-1:0]     ram_addr;
  logic [DATA_WIDTH-1:0] ram_rdata;
  fad_res_t              res;

  logic                  s1_valid;
  fad_res_t              s1_res;
  logic                  s1_advance;
  logic                  out_valid;
  logic [DATA_WIDTH-1:0] out_popped;
  status_t               out_status;

  assign s1_advance    = s1_valid & (~out_valid | m_axis_tready);
  assign s_axis_tready = ~s1_valid | s1_advance;
  assign accept        = s_axis_tvalid & s_axis_tready;

  fad_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .action (action_t'(s_axis_tuser)),
    .we     (ram_we),
    .re     (ram_re),
    .addr   (ram_addr),
    .res    (res)
  );

  fad_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_addr),
    .wdata (s_axis_tdata[DATA_WIDTH-1:0]),
    .re    (ram_re),
    .raddr (ram_addr),
    .rdata (ram_rdata)
  );

  // The RAM read data stays put while no new read is issued, so a stalled
  // beat in the middle stage keeps its popped word.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_advance) begin
        s1_valid <= 1'b0;
      end
      if (s1_advance) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_res <= res;
    end
    if (s1_advance) begin
      out_popped <= s1_res.pop_ok ? ram_rdata : '0;
      out_status <= s1_res.status;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = TDATA_W'(out_popped);
  assign m_axis_tuser  = out_status;

endmodule

@@ tb/tb_top.sv @@
module tb_top;
  import fad_pkg::*;

  localparam int DEPTH = 4;
  localparam int DATA_WIDTH = 32;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int RANDOM_OPS = 630;
  localparam int HOLD_CYCLES = 60;
  localparam int DRAIN_CYCLES = 10;

  typedef struct packed {
    action_t action;
    logic [DATA_WIDTH-1:0] word;
  } deque_op_t;

  typedef struct packed {
    logic [DATA_WIDTH-1:0] popped;
    status_t status;
  } deque_out_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [DATA_WIDTH-1:0] s_axis_tdata = '0;  // value
  logic [1:0] s_axis_tuser = ACT_PUSH_FRONT;  // action
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [DATA_WIDTH-1:0] m_axis_tdata;  // popped
  logic [2:0] m_axis_tuser;  // status

  deque_op_t pending_ops[$];
  deque_out_t predicted_q[$];

  // Shadow of the deque state.
  logic [DATA_WIDTH-1:0] slots[DEPTH];
  logic [2:0] head_idx = '0;
  logic [2:0] tail_idx = '0;
  logic in_use = 1'b0;

  bit beat_taken = 1'b0;
  int n_sent = 0;
  int n_results = 0;
  int n_errors = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  int status_count[5] = '{default: 0};

  fixed_array_deque #(
    .DEPTH(DEPTH),
    .DATA_WIDTH(DATA_WIDTH)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic deque_out_t deque_step(action_t act, logic [DATA_WIDTH-1:0] word);
    deque_out_t res;
    res.popped = '0;
    res.status = ST_OK;
    if (act == ACT_PUSH_FRONT || act == ACT_PUSH_BACK) begin
      if (!in_use) begin
        // The very first push lands at entry 0 whichever end it targets.
        in_use = 1'b1;
        head_idx = 3'd0;
        tail_idx = 3'd1;
        slots[0] = word;
      end else if (act == ACT_PUSH_FRONT) begin
        if (head_idx > 0) begin
          head_idx = head_idx - 3'd1;
          slots[head_idx[ADDR_W-1:0]] = word;
        end else begin
          res.status = ST_FRONT_FULL;
        end
      end else if (tail_idx < DEPTH) begin
        slots[tail_idx[ADDR_W-1:0]] = word;
        tail_idx = tail_idx + 3'd1;
      end else begin
        res.status = ST_REAR_FULL;
      end
    end else if (!in_use) begin
      res.status = ST_NEVER_USED;
    end else if (head_idx == tail_idx) begin
      res.status = ST_EMPTY;
    end else if (act == ACT_POP_FRONT) begin
      res.popped = slots[head_idx[ADDR_W-1:0]];
      head_idx = head_idx + 3'd1;
    end else begin
      tail_idx = tail_idx - 3'd1;
      res.popped = slots[tail_idx[ADDR_W-1:0]];
    end
    return res;
  endfunction

  task automatic add_op(action_t act, logic [DATA_WIDTH-1:0] word);
    deque_op_t op;
    op.action = act;
    op.word = word;
    pending_ops.push_back(op);
  endtask

  function automatic logic [DATA_WIDTH-1:0] random_word();
    case ($urandom_range(0, 9))
      0: return {1'b1, {(DATA_WIDTH-1){1'b0}}};
      1: return {1'b0, {(DATA_WIDTH-1){1'b1}}};
      2: return '1;
      3: return '0;
      default: return $urandom();
    endcase
  endfunction

  // No idling on either side while this window of input beats goes through.
  function automatic bit quiet_window();
    return n_sent >= 300 && n_sent < 420;
  endfunction

  // Input driver: a beat stays on the bus until it is taken.
  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || beat_taken) begin
      beat_taken = 1'b0;
      if (pending_ops.size() > 0 && (quiet_window() || $urandom_range(0, 99) >= 7)) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= pending_ops[0].action;
        s_axis_tdata <= pending_ops[0].word;
        void'(pending_ops.pop_front());
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Output receiver, with one long hold-off so the block backs up into its input.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (!hold_done && n_results >= 150) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= quiet_window() || ($urandom_range(0, 99) >= 7);
    end
  end

  // Monitor: predict on each accepted input beat, check each accepted output beat.
  always @(posedge clk) begin
    deque_out_t want;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        n_results++;
        if (predicted_q.size() == 0) begin
          $error("unexpected result beat: popped=%h status=%0d", m_axis_tdata, m_axis_tuser);
          n_errors++;
        end else begin
          want = predicted_q.pop_front();
          if (m_axis_tdata !== want.popped) begin
            $error("popped: expected %h, got %h", want.popped, m_axis_tdata);
            n_errors++;
          end
          if (m_axis_tuser !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, m_axis_tuser);
            n_errors++;
          end
          status_count[want.status]++;
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        beat_taken = 1'b1;
        n_sent++;
        predicted_q.push_back(deque_step(action_t'(s_axis_tuser), s_axis_tdata));
      end
    end
  end

  initial begin
    int push_pct;
    // Pops before any push, then the first push, both full conditions,
    // pops of the extreme words and pops of a started but empty deque.
    add_op(ACT_POP_FRONT, '0);
    add_op(ACT_POP_BACK, '1);
    add_op(ACT_PUSH_BACK, 32'h8000_0000);
    add_op(ACT_PUSH_FRONT, 32'h0000_0001);
    add_op(ACT_PUSH_BACK, 32'h7fff_ffff);
    add_op(ACT_PUSH_BACK, 32'hffff_ffff);
    add_op(ACT_PUSH_BACK, 32'h0000_0000);
    add_op(ACT_PUSH_BACK, 32'h0000_0005);
    add_op(ACT_POP_FRONT, '0);
    add_op(ACT_PUSH_FRONT, 32'h5a5a_5a5a);
    add_op(ACT_POP_BACK, '0);
    add_op(ACT_POP_BACK, '0);
    add_op(ACT_POP_BACK, '0);
    add_op(ACT_POP_FRONT, '0);
    add_op(ACT_POP_FRONT, '0);
    add_op(ACT_POP_BACK, '0);
    add_op(ACT_PUSH_FRONT, 32'ha5a5_a5a5);
    add_op(ACT_POP_BACK, '0);
    add_op(ACT_PUSH_BACK, 32'h1234_5678);
    add_op(ACT_POP_FRONT, '0);

    // Random part in bursts that lean toward pushes, toward pops or neither, so the
    // indices wander between the full and the empty ends.
    push_pct = 50;
    for (int i = 0; i < RANDOM_OPS; i++) begin
      if (i % 20 == 0) begin
        case ($urandom_range(0, 2))
          0: push_pct = 20;
          1: push_pct = 50;
          default: push_pct = 80;
        endcase
      end
      if ($urandom_range(0, 99) < push_pct) begin
        add_op($urandom_range(0, 1) ? ACT_PUSH_BACK : ACT_PUSH_FRONT, random_word());
      end else begin
        add_op($urandom_range(0, 1) ? ACT_POP_BACK : ACT_POP_FRONT, random_word());
      end
    end

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pending_ops.size() > 0 || s_axis_tvalid) @(posedge clk);
    while (predicted_q.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d actions through the deque and checked %0d result beats.",
             n_sent, n_results);
    $display("Status mix: ok %0d, front full %0d, rear full %0d, never used %0d, empty %0d.",
             status_count[ST_OK], status_count[ST_FRONT_FULL], status_count[ST_REAR_FULL],
             status_count[ST_NEVER_USED], status_count[ST_EMPTY]);
    if (n_errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("Timed out with %0d results still outstanding.", predicted_q.size());
    $display("DONE: errors detected");
    $finish;
  end

endmodule
